// ----- src/tsus_pkg.sv -----
// ----------------------------------------------------------------------------
// tsus_pkg: shared definitions for the timestamp text parser
// Character codes, field positions, arithmetic constants, calendar tables
// and the sequencer state type.
// ----------------------------------------------------------------------------
package tsus_pkg;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Character positions within one value
  localparam int unsigned POS_W = 5;
  localparam logic [POS_W-1:0] POS_YEAR_HI   = 5'd2;   // third year digit
  localparam logic [POS_W-1:0] POS_YEAR_LAST = 5'd3;
  localparam logic [POS_W-1:0] POS_DASH1     = 5'd4;
  localparam logic [POS_W-1:0] POS_MONTH_END = 5'd6;
  localparam logic [POS_W-1:0] POS_DASH2     = 5'd7;
  localparam logic [POS_W-1:0] POS_DAY_END   = 5'd9;
  localparam logic [POS_W-1:0] POS_SEP       = 5'd10;
  localparam logic [POS_W-1:0] POS_HOUR_END  = 5'd12;
  localparam logic [POS_W-1:0] POS_COLON1    = 5'd13;
  localparam logic [POS_W-1:0] POS_MIN_END   = 5'd15;
  localparam logic [POS_W-1:0] POS_COLON2    = 5'd16;
  localparam logic [POS_W-1:0] POS_SEC_END   = 5'd18;
  localparam logic [POS_W-1:0] POS_DOT       = 5'd19;
  localparam logic [POS_W-1:0] LEN_MIN       = 5'd19;
  localparam logic [POS_W-1:0] LEN_FRAC_MIN  = 5'd21;
  localparam logic [POS_W-1:0] LEN_MAX       = 5'd26;

  // Field widths
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned FLD_W  = 7;
  localparam int unsigned FRAC_W = 20;
  localparam int unsigned TS_W   = 59;

  // Range limits
  localparam logic [FLD_W-1:0] HOUR_MAX  = 7'd23;
  localparam logic [FLD_W-1:0] MIN_MAX   = 7'd59;
  localparam logic [FLD_W-1:0] MONTH_MAX = 7'd12;
  localparam logic [FLD_W-1:0] MONTH_FEB = 7'd2;

  // Shared multiply-add unit
  localparam int unsigned MUL_A_W = 49;
  localparam int unsigned MUL_B_W = 14;
  localparam int unsigned PROD_W  = 64;
  localparam logic [MUL_B_W-1:0] DEC_BASE       = 14'd10;
  localparam logic [MUL_B_W-1:0] DIV100_RECIP   = 14'd5243;  // 2^19 / 100, rounded up
  localparam int unsigned        DIV100_SHIFT   = 19;
  localparam logic [MUL_B_W-1:0] DAYS_PER_YEAR  = 14'd365;
  localparam logic [MUL_B_W-1:0] HOURS_PER_DAY  = 14'd24;
  localparam logic [MUL_B_W-1:0] SIXTY          = 14'd60;
  localparam logic [MUL_B_W-1:0] THOUSAND       = 14'd1000;
  localparam logic [MUL_B_W-1:0] UNIT_B         = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_BIAS      = 14'd400;

  // Days from 0000-03-01 (shifted by one 400-year era) to 1970-01-01
  localparam int unsigned LIN_W = 21;
  localparam logic signed [LIN_W-1:0] EPOCH_DAYS = 21'sd865565;

  // Sequencer states, one-hot
  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_CHECK = 12'b0000_0000_0010,
    S_CENT  = 12'b0000_0000_0100,
    S_QUAD  = 12'b0000_0000_1000,
    S_DAYS  = 12'b0000_0001_0000,
    S_ADJ   = 12'b0000_0010_0000,
    S_HOUR  = 12'b0000_0100_0000,
    S_MIN   = 12'b0000_1000_0000,
    S_SEC   = 12'b0001_0000_0000,
    S_MS    = 12'b0010_0000_0000,
    S_US    = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_t;

  // Days in a month of a common year
  function automatic logic [4:0] days_in_month(input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                       d = 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

  // Days before the month in a year that starts in March
  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd3:    d = 9'd0;
      4'd4:    d = 9'd31;
      4'd5:    d = 9'd61;
      4'd6:    d = 9'd92;
      4'd7:    d = 9'd122;
      4'd8:    d = 9'd153;
      4'd9:    d = 9'd184;
      4'd10:   d = 9'd214;
      4'd11:   d = 9'd245;
      4'd12:   d = 9'd275;
      4'd1:    d = 9'd306;
      4'd2:    d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Microsecond weight of a fraction digit by its character position
  function automatic logic [16:0] frac_weight(input logic [POS_W-1:0] p);
    logic [16:0] w;
    case (p)
      5'd20:   w = 17'd100000;
      5'd21:   w = 17'd10000;
      5'd22:   w = 17'd1000;
      5'd23:   w = 17'd100;
      5'd24:   w = 17'd10;
      5'd25:   w = 17'd1;
      default: w = 17'd0;
    endcase
    return w;
  endfunction

endpackage

// ----- src/timestamp_text_to_microseconds.sv -----
// ----------------------------------------------------------------------------
// timestamp_text_to_microseconds: streaming timestamp text parser
// Checks "YYYY-MM-DD[ T]hh:mm:ss[.f{1,6}]" one character at a time and
// converts it to signed microseconds since 1970-01-01 00:00:00.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one character per request, with
//   in_last_char set on the final character of a value. Characters other
//   than the last are taken one per cycle while idle and produce no result.
//   Output channel (out_valid/out_ready): one result per value, a valid flag
//   and the timestamp (zero when the text is malformed).
// Sequencing:
//   After the final character the block runs a check step and, for a
//   well-formed value, nine steps of one shared multiply-add unit (day
//   count, hours, minutes, seconds, scaling to microseconds). A malformed
//   value goes from the check step straight to the result. The block takes
//   no character of the next value until the result has been taken.
// Reset: rst_n clears the sequencer and the per-value state; the block then
//   waits for the first character.
// Stall: while a result waits for out_ready, in_ready stays low.
// ----------------------------------------------------------------------------
module timestamp_text_to_microseconds
  import tsus_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_char_code,
  input  logic                   in_last_char,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_valid_res,
  output logic signed [TS_W-1:0] out_timestamp_us
);

  state_t state_r, state_nxt;

  // Per-value parse state
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              bad_r, bad_nxt;
  logic [YEAR_W-1:0] year_r, year_nxt;
  logic [FLD_W-1:0]  month_r, month_nxt;
  logic [FLD_W-1:0]  day_r, day_nxt;
  logic [FLD_W-1:0]  hour_r, hour_nxt;
  logic [FLD_W-1:0]  minute_r, minute_nxt;
  logic [FLD_W-1:0]  second_r, second_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [1:0]        cent_lo_r, cent_lo_nxt;   // year / 100, low two bits
  logic              zz_r, zz_nxt;             // last two year digits are zero

  // Datapath registers
  logic signed [LIN_W-1:0] lin_r;
  logic [6:0]              cent_r;
  logic [4:0]              quad_r;
  logic signed [TS_W-1:0]  acc_r;
  logic                    out_res_r;
  logic signed [TS_W-1:0]  out_ts_r;

  logic in_acc, out_acc;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign in_acc    = in_valid & in_ready;
  assign out_acc   = out_valid & out_ready;
  assign out_valid_res    = out_res_r;
  assign out_timestamp_us = out_ts_r;

  // Character absorb: form check and decimal accumulation
  logic        is_digit, char_ok;
  logic [3:0]  dval;
  logic [17:0] year_mul;
  logic [10:0] fld_mul;
  logic [FLD_W-1:0] fld_cur;
  logic [33:0] frac_add;

  always_comb begin
    is_digit    = (in_char_code >= CH_ZERO) && (in_char_code <= CH_NINE);
    dval        = 4'(in_char_code - CH_ZERO);
    year_nxt    = year_r;
    month_nxt   = month_r;
    day_nxt     = day_r;
    hour_nxt    = hour_r;
    minute_nxt  = minute_r;
    second_nxt  = second_r;
    frac_nxt    = frac_r;
    cent_lo_nxt = cent_lo_r;
    zz_nxt      = zz_r;
    char_ok     = 1'b0;
    year_mul    = 18'(year_r) * 18'(DEC_BASE) + 18'(dval);
    if (pos_r <= POS_MONTH_END)     fld_cur = month_r;
    else if (pos_r <= POS_DAY_END)  fld_cur = day_r;
    else if (pos_r <= POS_HOUR_END) fld_cur = hour_r;
    else if (pos_r <= POS_MIN_END)  fld_cur = minute_r;
    else                            fld_cur = second_r;
    fld_mul  = 11'(fld_cur) * 11'(DEC_BASE) + 11'(dval);
    frac_add = 34'(frac_r) + 34'(dval) * 34'(frac_weight(pos_r));

    if (pos_r >= LEN_MAX) begin
      char_ok = 1'b0;
    end else if (pos_r <= POS_YEAR_LAST) begin
      char_ok = is_digit;
      if (is_digit) year_nxt = year_mul[YEAR_W-1:0];
      // century low bits and trailing-zero tracking for the leap rule
      if (pos_r == POS_YEAR_HI) begin
        cent_lo_nxt = year_r[1:0];
        zz_nxt      = (in_char_code == CH_ZERO);
      end else if (pos_r == POS_YEAR_LAST) begin
        zz_nxt = zz_r & (in_char_code == CH_ZERO);
      end
    end else if (pos_r == POS_DASH1 || pos_r == POS_DASH2) begin
      char_ok = (in_char_code == CH_DASH);
    end else if (pos_r <= POS_MONTH_END) begin
      char_ok = is_digit;
      if (is_digit) month_nxt = fld_mul[FLD_W-1:0];
    end else if (pos_r <= POS_DAY_END) begin
      char_ok = is_digit;
      if (is_digit) day_nxt = fld_mul[FLD_W-1:0];
    end else if (pos_r == POS_SEP) begin
      char_ok = (in_char_code == CH_SPACE) || (in_char_code == CH_T);
    end else if (pos_r == POS_COLON1 || pos_r == POS_COLON2) begin
      char_ok = (in_char_code == CH_COLON);
    end else if (pos_r <= POS_HOUR_END) begin
      char_ok = is_digit;
      if (is_digit) hour_nxt = fld_mul[FLD_W-1:0];
    end else if (pos_r <= POS_MIN_END) begin
      char_ok = is_digit;
      if (is_digit) minute_nxt = fld_mul[FLD_W-1:0];
    end else if (pos_r <= POS_SEC_END) begin
      char_ok = is_digit;
      if (is_digit) second_nxt = fld_mul[FLD_W-1:0];
    end else if (pos_r == POS_DOT) begin
      char_ok = (in_char_code == CH_DOT);
    end else begin
      char_ok = is_digit;
      if (is_digit) frac_nxt = frac_add[FRAC_W-1:0];
    end

    pos_nxt = (pos_r >= LEN_MAX) ? pos_r : pos_r + 5'd1;
    bad_nxt = bad_r | ~char_ok;
  end

  // Value check on the complete text
  logic       leap, mon_ok, day_ok, time_ok, len_ok, val_ok;
  logic [4:0] day_lim;

  always_comb begin
    leap    = ((year_r[1:0] == 2'd0) && !zz_r) || (zz_r && (cent_lo_r == 2'd0));
    mon_ok  = (month_r != '0) && (month_r <= MONTH_MAX);
    day_lim = days_in_month(month_r[3:0]) + 5'((month_r == MONTH_FEB) && leap);
    day_ok  = (day_r != '0) && (day_r <= 7'(day_lim));
    time_ok = (hour_r <= HOUR_MAX) && (minute_r <= MIN_MAX) && (second_r <= MIN_MAX);
    len_ok  = (pos_r == LEN_MIN) || ((pos_r >= LEN_FRAC_MIN) && (pos_r <= LEN_MAX));
    val_ok  = !bad_r && len_ok && mon_ok && day_ok && time_ok;
  end

  // Shifted year, day of year and the linear part of the day count
  logic [YEAR_W-1:0]       yy;
  logic [8:0]              doy;
  logic signed [LIN_W-1:0] lin_val;

  always_comb begin
    yy      = year_r + YEAR_BIAS - YEAR_W'(month_r <= MONTH_FEB);
    doy     = days_before_month(month_r[3:0]) + 9'(day_r) - 9'd1;
    lin_val = $signed({9'd0, yy[YEAR_W-1:2]}) + $signed({12'd0, doy}) - EPOCH_DAYS;
  end

  // Shared multiply-add unit: acc_nxt = base + a * b
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [TS_W-1:0]    base;
  logic signed [PROD_W-1:0]  prod;
  logic signed [TS_W-1:0]    acc_nxt;
  logic signed [7:0]         adj;

  always_comb begin
    adj   = $signed({3'd0, quad_r}) - $signed({1'b0, cent_r});
    mul_a = MUL_A_W'(acc_r);
    mul_b = UNIT_B;
    base  = '0;
    case (state_r)
      S_CENT: begin
        mul_a = $signed(MUL_A_W'(yy));
        mul_b = DIV100_RECIP;
      end
      S_QUAD: begin
        mul_a = $signed(MUL_A_W'(yy[YEAR_W-1:2]));
        mul_b = DIV100_RECIP;
      end
      S_DAYS: begin
        mul_a = $signed(MUL_A_W'(yy));
        mul_b = DAYS_PER_YEAR;
        base  = TS_W'(lin_r);
      end
      S_ADJ: begin
        mul_a = MUL_A_W'(adj);
        mul_b = UNIT_B;
        base  = acc_r;
      end
      S_HOUR: begin
        mul_b = HOURS_PER_DAY;
        base  = $signed(TS_W'(hour_r));
      end
      S_MIN: begin
        mul_b = SIXTY;
        base  = $signed(TS_W'(minute_r));
      end
      S_SEC: begin
        mul_b = SIXTY;
        base  = $signed(TS_W'(second_r));
      end
      S_MS: begin
        mul_b = THOUSAND;
      end
      S_US: begin
        mul_b = THOUSAND;
        base  = $signed(TS_W'(frac_r));
      end
      default: begin
        mul_b = UNIT_B;
      end
    endcase
    prod    = PROD_W'(mul_a) * $signed(PROD_W'(mul_b));
    acc_nxt = base + prod[TS_W-1:0];
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc && in_last_char) state_nxt = S_CHECK;
      S_CHECK: state_nxt = val_ok ? S_CENT : S_OUT;
      S_CENT:  state_nxt = S_QUAD;
      S_QUAD:  state_nxt = S_DAYS;
      S_DAYS:  state_nxt = S_ADJ;
      S_ADJ:   state_nxt = S_HOUR;
      S_HOUR:  state_nxt = S_MIN;
      S_MIN:   state_nxt = S_SEC;
      S_SEC:   state_nxt = S_MS;
      S_MS:    state_nxt = S_US;
      S_US:    state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and per-value state
  always_ff @(posedge clk) begin
    if (!rst_n || out_acc) begin
      state_r   <= (!rst_n) ? S_IDLE : state_nxt;
      pos_r     <= '0;
      bad_r     <= 1'b0;
      year_r    <= '0;
      month_r   <= '0;
      day_r     <= '0;
      hour_r    <= '0;
      minute_r  <= '0;
      second_r  <= '0;
      frac_r    <= '0;
      cent_lo_r <= '0;
      zz_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        pos_r     <= pos_nxt;
        bad_r     <= bad_nxt;
        year_r    <= year_nxt;
        month_r   <= month_nxt;
        day_r     <= day_nxt;
        hour_r    <= hour_nxt;
        minute_r  <= minute_nxt;
        second_r  <= second_nxt;
        frac_r    <= frac_nxt;
        cent_lo_r <= cent_lo_nxt;
        zz_r      <= zz_nxt;
      end
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_CHECK: begin
        lin_r     <= lin_val;
        out_res_r <= 1'b0;
        out_ts_r  <= '0;
      end
      S_CENT:  cent_r <= prod[DIV100_SHIFT+6:DIV100_SHIFT];
      S_QUAD:  quad_r <= prod[DIV100_SHIFT+4:DIV100_SHIFT];
      S_US: begin
        out_res_r <= 1'b1;
        out_ts_r  <= acc_nxt;
      end
      default: acc_r <= acc_nxt;
    endcase
  end

endmodule

// ----- src/timestamp_text_to_microseconds_chk.sv -----
// ----------------------------------------------------------------------------
// timestamp_text_to_microseconds_chk: port-level checks for the parser
// Watches both channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module timestamp_text_to_microseconds_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [7:0]          in_char_code,
  input logic                in_last_char,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_valid_res,
  input logic signed [58:0]  out_timestamp_us
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_valid_res)
                                && $stable(out_timestamp_us))
    else $error("result changed while stalled");

  // A malformed value reports a zero timestamp
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_timestamp_us == '0)
    else $error("invalid result with nonzero timestamp");

  // The final character makes the block busy
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_char |=> !in_ready)
    else $error("request taken right after final character");

  // No new characters while a result is pending
  a_one_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input open while result pending");

  // A character that is not final produces no result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last_char |=> !out_valid)
    else $error("result without final character");

endmodule

bind timestamp_text_to_microseconds timestamp_text_to_microseconds_chk u_chk (.*);
